/* design/cdtmc_pkg.sv */
`default_nettype none

package cdtmc_pkg;

    localparam logic [2:0] ACT_INC   = 3'd0;
    localparam logic [2:0] ACT_DEC   = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_TICK  = 3'd3;
    localparam logic [2:0] ACT_ABORT = 3'd4;

    localparam logic [1:0] ST_HANDLED = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_TRANS   = 2'd2;

    localparam logic [1:0] MSG_NONE   = 2'd0;
    localparam logic [1:0] MSG_SET    = 2'd1;
    localparam logic [1:0] MSG_PAUSED = 2'd2;
    localparam logic [1:0] MSG_PROD   = 2'd3;

    localparam logic [1:0] REG_TIME_STEP    = 2'd0;
    localparam logic [1:0] REG_BEEP_PHASE   = 2'd1;
    localparam logic [1:0] REG_SECOND_PHASE = 2'd2;
    localparam logic [1:0] REG_STAT_TICKS   = 2'd3;

    localparam logic [11:0] TIME_STEP_RST    = 12'd60;
    localparam logic [3:0]  BEEP_PHASE_RST   = 4'd5;
    localparam logic [3:0]  SECOND_PHASE_RST = 4'd10;
    localparam logic [7:0]  STAT_TICKS_RST   = 8'd20;

    localparam int CFG_DATA_BITS = 12;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] subsecond;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  mode_now;
        logic [15:0] shown_time;
        logic [31:0] productive_seconds;
        logic        beep;
        logic [1:0]  message;
        logic        clear_display;
    } out_item_t;

endpackage

`default_nettype wire

/* design/countdown_timer_mode_controller_core.sv */
`default_nettype none

// channel   ports                     transfer when
// -------   -----------------------   -------------------
// input     s_valid s_ready s_data    s_valid && s_ready
// result    m_valid m_ready m_data    m_valid && m_ready
// config    cfg_we cfg_index cfg_wdata  cfg_we
//
// one event per cycle: the result is computed in the cycle of the input transfer
// and held in the output register, so an event sees the state left by the one before
// s_ready is high while the output register is empty or being drained
// a stall on m_ready holds the result and blocks new input transfers
// reset (aresetn low, synchronous) returns to idle, zero times, default registers

module countdown_timer_mode_controller_core
    import cdtmc_pkg::*;
#(
    parameter int TIME_BITS = 16
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire in_item_t            s_data,
    output logic                     m_valid,
    input  wire                      m_ready,
    output out_item_t                m_data,
    input  wire                      cfg_we,
    input  wire [1:0]                cfg_index,
    input  wire [CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int EXT_BITS = ((TIME_BITS > 12) ? TIME_BITS : 12) + 1;
    localparam logic [EXT_BITS-1:0] TIME_MAX_EXT = EXT_BITS'({TIME_BITS{1'b1}});

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SET   = 3'd1,
        MODE_COUNT = 3'd2,
        MODE_PAUSE = 3'd3,
        MODE_STATS = 3'd4
    } mode_t;

    logic [11:0]          time_step_reg;
    logic [3:0]           beep_phase_reg;
    logic [3:0]           second_phase_reg;
    logic [7:0]           stat_ticks_reg;

    mode_t                mode_reg, mode_next;
    logic [TIME_BITS-1:0] set_reg, set_next;
    logic [TIME_BITS-1:0] elap_reg, elap_next;
    logic [31:0]          prod_reg, prod_next;
    logic [7:0]           cnt_reg, cnt_next;

    logic                 m_valid_reg;
    out_item_t            m_data_reg, m_data_next;

    logic                 in_xfer;
    logic [EXT_BITS-1:0]  set_ext, step_ext, set_add_ext;
    logic [TIME_BITS-1:0] set_add_sat, set_sub;
    logic                 set_ge_step;
    logic                 tick_beep, tick_sec;
    logic [32:0]          prod_sum;
    logic [31:0]          set_wide;
    logic [1:0]           status;
    logic                 beep;
    logic [1:0]           msg;
    logic                 clr;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign set_ext     = EXT_BITS'(set_reg);
    assign step_ext    = EXT_BITS'(time_step_reg);
    assign set_add_ext = set_ext + step_ext;
    assign set_add_sat = (set_add_ext > TIME_MAX_EXT) ? {TIME_BITS{1'b1}}
                                                      : set_add_ext[TIME_BITS-1:0];
    assign set_ge_step = set_ext >= step_ext;
    assign set_sub     = TIME_BITS'(set_ext - step_ext);
    assign tick_beep   = (s_data.action == ACT_TICK) && (s_data.subsecond == beep_phase_reg);
    assign tick_sec    = (s_data.action == ACT_TICK) && (s_data.subsecond == second_phase_reg);

    always_comb begin
        set_next  = set_reg;
        elap_next = elap_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        mode_next = mode_reg;
        status    = ST_IGNORED;
        beep      = 1'b0;
        msg       = MSG_NONE;
        clr       = 1'b0;
        prod_sum  = 33'd0;

        unique case (mode_reg)
            MODE_SET: begin
                if (s_data.action == ACT_INC) begin
                    set_next = set_add_sat;
                    status   = ST_HANDLED;
                end else if (s_data.action == ACT_DEC) begin
                    if (set_ge_step) begin
                        set_next = set_sub;
                        status   = ST_HANDLED;
                    end
                end else if (s_data.action == ACT_START) begin
                    if (set_ge_step) begin
                        mode_next = MODE_COUNT;
                    end
                end else if (s_data.action == ACT_ABORT) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_COUNT: begin
                if (s_data.action == ACT_START) begin
                    mode_next = MODE_PAUSE;
                end else if (s_data.action == ACT_ABORT) begin
                    mode_next = MODE_IDLE;
                end else if (tick_sec) begin
                    if (set_reg != '0) begin
                        set_next = set_reg - TIME_BITS'(1);
                    end
                    if (elap_reg != {TIME_BITS{1'b1}}) begin
                        elap_next = elap_reg + TIME_BITS'(1);
                    end
                    if (set_reg <= TIME_BITS'(1)) begin
                        mode_next = MODE_IDLE;
                    end else begin
                        status = ST_HANDLED;
                    end
                end
            end
            MODE_PAUSE: begin
                if (s_data.action == ACT_INC) begin
                    set_next  = set_add_sat;
                    mode_next = MODE_SET;
                end else if (s_data.action == ACT_DEC) begin
                    if (set_ge_step) begin
                        set_next = set_sub;
                        status   = ST_HANDLED;
                    end
                end else if (s_data.action == ACT_ABORT) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_STATS: begin
                if (s_data.action == ACT_TICK) begin
                    if (cnt_reg >= stat_ticks_reg) begin
                        cnt_next  = 8'd0;
                        mode_next = MODE_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 8'd1;
                    end
                end
            end
            default: begin
                if (s_data.action == ACT_INC) begin
                    set_next  = set_add_sat;
                    mode_next = MODE_SET;
                end else if (s_data.action == ACT_START) begin
                    mode_next = MODE_STATS;
                end else if (tick_beep) begin
                    beep   = 1'b1;
                    status = ST_HANDLED;
                end
            end
        endcase

        if (mode_next != mode_reg) begin
            clr    = 1'b1;
            status = ST_TRANS;
            if (mode_reg == MODE_COUNT) begin
                prod_sum  = {1'b0, prod_reg} + 33'(elap_next);
                prod_next = prod_sum[32] ? 32'hFFFF_FFFF : prod_sum[31:0];
                elap_next = '0;
            end
            if (mode_next == MODE_IDLE) begin
                set_next  = '0;
                elap_next = '0;
                msg       = MSG_SET;
            end else if (mode_next == MODE_PAUSE) begin
                msg = MSG_PAUSED;
            end else if (mode_next == MODE_STATS) begin
                msg = MSG_PROD;
            end
        end

        set_wide = 32'(set_next);

        m_data_next.status             = status;
        m_data_next.mode_now           = mode_next;
        m_data_next.productive_seconds = prod_next;
        m_data_next.beep               = beep;
        m_data_next.message            = msg;
        m_data_next.clear_display      = clr;
        if (mode_next == MODE_STATS) begin
            m_data_next.shown_time = (prod_next > 32'h0000_FFFF) ? 16'hFFFF : prod_next[15:0];
        end else begin
            m_data_next.shown_time = (set_wide > 32'h0000_FFFF) ? 16'hFFFF : set_wide[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg    <= TIME_STEP_RST;
            beep_phase_reg   <= BEEP_PHASE_RST;
            second_phase_reg <= SECOND_PHASE_RST;
            stat_ticks_reg   <= STAT_TICKS_RST;
            mode_reg         <= MODE_IDLE;
            set_reg          <= '0;
            elap_reg         <= '0;
            prod_reg         <= '0;
            cnt_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TIME_STEP:    time_step_reg    <= cfg_wdata;
                    REG_BEEP_PHASE:   beep_phase_reg   <= cfg_wdata[3:0];
                    REG_SECOND_PHASE: second_phase_reg <= cfg_wdata[3:0];
                    REG_STAT_TICKS:   stat_ticks_reg   <= cfg_wdata[7:0];
                    default:          ;
                endcase
            end
            if (in_xfer) begin
                mode_reg    <= mode_next;
                set_reg     <= set_next;
                elap_reg    <= elap_next;
                prod_reg    <= prod_next;
                cnt_reg     <= cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            m_data_reg <= m_data_next;
        end
    end

    // a prompt only comes with a mode change
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.message != MSG_NONE) |-> m_data.clear_display)
        else $error("prompt without transition");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.clear_display == (m_data.status == ST_TRANS)))
        else $error("clear flag and transition status disagree");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.beep |-> (m_data.mode_now == MODE_IDLE)
                                   && (m_data.status == ST_HANDLED))
        else $error("beep outside idle");

    // the reported mode is the one kept for the next event
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (m_data.mode_now == mode_reg))
        else $error("reported mode differs from state");

    // productive time never goes down
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |-> (prod_next >= prod_reg))
        else $error("productive time decreased");

endmodule

`default_nettype wire

/* bench/countdown_timer_mode_controller_core_tb.sv */
`timescale 1ns / 100ps

module countdown_timer_mode_controller_core_tb;
    import cdtmc_pkg::*;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_SET   = 3'd1;
    localparam logic [2:0] MODE_COUNT = 3'd2;
    localparam logic [2:0] MODE_PAUSE = 3'd3;
    localparam logic [2:0] MODE_STATS = 3'd4;

    localparam logic [2:0] ACT_BAD_LO = 3'd5;
    localparam logic [2:0] ACT_BAD_HI = 3'd7;

    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 2;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_ITEMS     = 200;
    localparam int NUM_DIR_ROWS   = 26;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        in_item_t   ev;
        logic [7:0] reps;
        logic       typed;
        out_item_t  want;
    } dir_row_t;

    logic      aclk;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_data;
    logic      cfg_we    = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    // predictor copy of registers and state
    logic [11:0] cfg_step       = TIME_STEP_RST;
    logic [3:0]  cfg_beep_ph    = BEEP_PHASE_RST;
    logic [3:0]  cfg_sec_ph     = SECOND_PHASE_RST;
    logic [7:0]  cfg_stat_ticks = STAT_TICKS_RST;

    logic [2:0]  tm_mode       = MODE_IDLE;
    logic [15:0] tm_set_secs   = '0;
    logic [15:0] tm_elapsed    = '0;
    logic [31:0] tm_productive = '0;
    logic [7:0]  tm_stat_count = '0;

    out_item_t   timer_results_due [$];
    dir_row_t    dir_rows [NUM_DIR_ROWS];
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned inc_burst     = 0;
    int unsigned mismatches    = 0;
    int unsigned quiet_cycles  = 0;

    countdown_timer_mode_controller_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [15:0] add_sat16(logic [15:0] a, logic [15:0] b);
        logic [16:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

    function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic out_item_t advance_timer(in_item_t ev);
        out_item_t   res;
        logic [2:0]  nxt;
        logic [1:0]  stat;
        logic [1:0]  msg;
        logic        beep;
        logic        clr;
        logic [15:0] step16;
        step16 = {4'd0, cfg_step};
        stat   = ST_IGNORED;
        msg    = MSG_NONE;
        beep   = 1'b0;
        clr    = 1'b0;
        nxt    = tm_mode;
        case (tm_mode)
            MODE_IDLE: begin
                if (ev.action == ACT_INC) begin
                    tm_set_secs = add_sat16(tm_set_secs, step16);
                    nxt = MODE_SET;
                end else if (ev.action == ACT_START) begin
                    nxt = MODE_STATS;
                end else if (ev.action == ACT_TICK && ev.subsecond == cfg_beep_ph) begin
                    beep = 1'b1;
                    stat = ST_HANDLED;
                end
            end
            MODE_SET: begin
                if (ev.action == ACT_INC) begin
                    tm_set_secs = add_sat16(tm_set_secs, step16);
                    stat = ST_HANDLED;
                end else if (ev.action == ACT_DEC) begin
                    if (tm_set_secs >= step16) begin
                        tm_set_secs = tm_set_secs - step16;
                        stat = ST_HANDLED;
                    end
                end else if (ev.action == ACT_START) begin
                    if (tm_set_secs >= step16) nxt = MODE_COUNT;
                end else if (ev.action == ACT_ABORT) begin
                    nxt = MODE_IDLE;
                end
            end
            MODE_COUNT: begin
                if (ev.action == ACT_START) begin
                    nxt = MODE_PAUSE;
                end else if (ev.action == ACT_ABORT) begin
                    nxt = MODE_IDLE;
                end else if (ev.action == ACT_TICK && ev.subsecond == cfg_sec_ph) begin
                    if (tm_set_secs != 16'd0) tm_set_secs = tm_set_secs - 16'd1;
                    tm_elapsed = add_sat16(tm_elapsed, 16'd1);
                    if (tm_set_secs == 16'd0) nxt = MODE_IDLE;
                    else stat = ST_HANDLED;
                end
            end
            MODE_PAUSE: begin
                if (ev.action == ACT_INC) begin
                    tm_set_secs = add_sat16(tm_set_secs, step16);
                    nxt = MODE_SET;
                end else if (ev.action == ACT_DEC) begin
                    if (tm_set_secs >= step16) begin
                        tm_set_secs = tm_set_secs - step16;
                        stat = ST_HANDLED;
                    end
                end else if (ev.action == ACT_ABORT) begin
                    nxt = MODE_IDLE;
                end
            end
            default: begin
                if (ev.action == ACT_TICK) begin
                    if (tm_stat_count >= cfg_stat_ticks) begin
                        tm_stat_count = 8'd0;
                        nxt = MODE_IDLE;
                    end else begin
                        tm_stat_count = tm_stat_count + 8'd1;
                    end
                end
            end
        endcase

        // exit action of the old mode, then entry action of the new one
        if (nxt != tm_mode) begin
            clr = 1'b1;
            if (tm_mode == MODE_COUNT) begin
                tm_productive = add_sat32(tm_productive, {16'd0, tm_elapsed});
                tm_elapsed = 16'd0;
            end
            if (nxt == MODE_IDLE) begin
                tm_set_secs = 16'd0;
                tm_elapsed  = 16'd0;
                msg = MSG_SET;
            end else if (nxt == MODE_PAUSE) begin
                msg = MSG_PAUSED;
            end else if (nxt == MODE_STATS) begin
                msg = MSG_PROD;
            end
            tm_mode = nxt;
            stat = ST_TRANS;
        end

        res.status             = stat;
        res.mode_now           = tm_mode;
        res.shown_time         = (tm_mode == MODE_STATS) ?
                                 ((tm_productive > 32'hFFFF) ? 16'hFFFF : tm_productive[15:0]) :
                                 tm_set_secs;
        res.productive_seconds = tm_productive;
        res.beep               = beep;
        res.message            = msg;
        res.clear_display      = clr;
        return res;
    endfunction

    // mostly legal sequences for the current mode, with bursts of increments and some noise
    function automatic in_item_t pick_event();
        in_item_t    ev;
        int unsigned r;
        ev.subsecond = 4'($urandom_range(15));
        ev.action    = ACT_TICK;
        r = $urandom_range(99);
        if (inc_burst != 0) begin
            inc_burst = inc_burst - 1;
            ev.action = ACT_INC;
        end else if (r < 4) begin
            ev.action = 3'($urandom_range(ACT_BAD_HI, ACT_BAD_LO));
        end else if (tm_mode == MODE_COUNT || tm_mode == MODE_STATS) begin
            if (r < 92) begin
                ev.action = ACT_TICK;
                if ($urandom_range(3) != 0) ev.subsecond = cfg_sec_ph;
            end else if (r < 96) begin
                ev.action = ACT_START;
            end else begin
                ev.action = ACT_ABORT;
            end
        end else begin
            if (r < 12) begin
                inc_burst = $urandom_range(23);
                ev.action = ACT_INC;
            end else if (r < 35) begin
                ev.action = ACT_INC;
            end else if (r < 52) begin
                ev.action = ACT_DEC;
            end else if (r < 68) begin
                ev.action = ACT_START;
            end else if (r < 76) begin
                ev.action = ACT_ABORT;
            end else begin
                ev.action = ACT_TICK;
                if (tm_mode == MODE_IDLE && $urandom_range(1) != 0) ev.subsecond = cfg_beep_ph;
            end
        end
        return ev;
    endfunction

    function automatic dir_row_t row_pred(logic [2:0] act, logic [3:0] ss, logic [7:0] reps);
        dir_row_t row;
        row              = '0;
        row.ev.action    = act;
        row.ev.subsecond = ss;
        row.reps         = reps;
        return row;
    endfunction

    function automatic dir_row_t row_typed(logic [2:0] act, logic [3:0] ss, logic [1:0] stat,
                                           logic [2:0] md, logic [15:0] shown,
                                           logic [31:0] prod, logic beep, logic [1:0] msg,
                                           logic clr);
        dir_row_t row;
        row                         = row_pred(act, ss, 8'd1);
        row.typed                   = 1'b1;
        row.want.status             = stat;
        row.want.mode_now           = md;
        row.want.shown_time         = shown;
        row.want.productive_seconds = prod;
        row.want.beep               = beep;
        row.want.message            = msg;
        row.want.clear_display      = clr;
        return row;
    endfunction

    task automatic report_error(string text);
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS) $display("mismatch: %s", text);
    endtask

    task automatic compare_field(string fld, logic [31:0] want, logic [31:0] got);
        if (want !== got) report_error($sformatf("%s expected %0d, got %0d", fld, want, got));
    endtask

    task automatic push_event(in_item_t ev, logic typed, out_item_t typed_want);
        out_item_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = advance_timer(ev);
        timer_results_due.push_back(typed ? typed_want : predicted);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (timer_results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic load_config(logic [11:0] step_val, logic [3:0] bphase, logic [3:0] sphase,
                               logic [7:0] sticks);
        logic [11:0] junk;
        junk = 12'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TIME_STEP;
        cfg_wdata <= step_val;
        @(posedge aclk);
        cfg_index <= REG_BEEP_PHASE;
        cfg_wdata <= {junk[11:4], bphase};
        @(posedge aclk);
        cfg_index <= REG_SECOND_PHASE;
        cfg_wdata <= {junk[7:0], sphase};
        @(posedge aclk);
        cfg_index <= REG_STAT_TICKS;
        cfg_wdata <= {junk[11:8], sticks};
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_step       = step_val;
        cfg_beep_ph    = bphase;
        cfg_sec_ph     = sphase;
        cfg_stat_ticks = sticks;
    endtask

    task automatic run_phase(logic [11:0] step_val, logic [3:0] bphase, logic [3:0] sphase,
                             logic [7:0] sticks);
        int k;
        drain_results();
        load_config(step_val, bphase, sphase, sticks);
        inc_burst = 0;
        for (k = 0; k < RAND_ITEMS; k++) begin
            if (k == RAND_ITEMS / 2) drain_results();
            push_event(pick_event(), 1'b0, '0);
        end
    endtask

    // result side: check each transfer, then choose ready for the next cycle
    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (timer_results_due.size() == 0) begin
                report_error($sformatf("result transfer with nothing expected: %h", m_data));
            end else begin
                want = timer_results_due.pop_front();
                compare_field("status", 32'(want.status), 32'(m_data.status));
                compare_field("mode_now", 32'(want.mode_now), 32'(m_data.mode_now));
                compare_field("shown_time", 32'(want.shown_time), 32'(m_data.shown_time));
                compare_field("productive_seconds", want.productive_seconds,
                              m_data.productive_seconds);
                compare_field("beep", 32'(want.beep), 32'(m_data.beep));
                compare_field("message", 32'(want.message), 32'(m_data.message));
                compare_field("clear_display", 32'(want.clear_display),
                              32'(m_data.clear_display));
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("countdown_timer_mode_controller_core_tb failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int i;
        int n;
        dir_rows = '{
            row_typed(ACT_TICK, 4'd5, ST_HANDLED, MODE_IDLE, 16'd0, 32'd0, 1'b1, MSG_NONE, 1'b0),
            row_typed(ACT_TICK, 4'd15, ST_IGNORED, MODE_IDLE, 16'd0, 32'd0, 1'b0, MSG_NONE, 1'b0),
            row_typed(ACT_BAD_HI, 4'd0, ST_IGNORED, MODE_IDLE, 16'd0, 32'd0, 1'b0, MSG_NONE,
                      1'b0),
            row_typed(ACT_DEC, 4'd15, ST_IGNORED, MODE_IDLE, 16'd0, 32'd0, 1'b0, MSG_NONE, 1'b0),
            row_typed(ACT_ABORT, 4'd0, ST_IGNORED, MODE_IDLE, 16'd0, 32'd0, 1'b0, MSG_NONE, 1'b0),
            row_typed(ACT_INC, 4'd0, ST_TRANS, MODE_SET, 16'd60, 32'd0, 1'b0, MSG_NONE, 1'b1),
            row_pred(ACT_INC, 4'd15, 8'd1),
            row_pred(ACT_DEC, 4'd0, 8'd1),
            row_pred(ACT_BAD_LO, 4'd3, 8'd1),
            row_pred(ACT_START, 4'd0, 8'd1),
            row_pred(ACT_TICK, 4'd10, 8'd1),
            row_pred(ACT_TICK, 4'd0, 8'd1),
            row_typed(ACT_START, 4'd0, ST_TRANS, MODE_PAUSE, 16'd59, 32'd1, 1'b0, MSG_PAUSED,
                      1'b1),
            row_pred(ACT_DEC, 4'd0, 8'd1),
            row_pred(ACT_START, 4'd0, 8'd1),
            row_pred(ACT_TICK, 4'd10, 8'd1),
            row_pred(ACT_INC, 4'd0, 8'd1),
            row_typed(ACT_ABORT, 4'd0, ST_TRANS, MODE_IDLE, 16'd0, 32'd1, 1'b0, MSG_SET, 1'b1),
            row_typed(ACT_START, 4'd0, ST_TRANS, MODE_STATS, 16'd1, 32'd1, 1'b0, MSG_PROD, 1'b1),
            row_pred(ACT_INC, 4'd0, 8'd1),
            row_pred(ACT_TICK, 4'd0, 8'd20),
            row_typed(ACT_TICK, 4'd15, ST_TRANS, MODE_IDLE, 16'd0, 32'd1, 1'b0, MSG_SET, 1'b1),
            row_pred(ACT_INC, 4'd0, 8'd1),
            row_pred(ACT_START, 4'd0, 8'd1),
            row_pred(ACT_TICK, 4'd10, 8'd59),
            row_typed(ACT_TICK, 4'd10, ST_TRANS, MODE_IDLE, 16'd0, 32'd61, 1'b0, MSG_SET, 1'b1)
        };

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 8;
        recv_idle_pct = 50;
        for (i = 0; i < NUM_DIR_ROWS; i++) begin
            for (n = 0; n < int'(dir_rows[i].reps); n++) begin
                push_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        run_phase(12'd60, 4'd5, 4'd10, 8'd20);
        run_phase(12'd1, 4'd0, 4'd15, 8'd255);

        send_idle_pct = 50;
        recv_idle_pct = 8;
        run_phase(12'd3600, 4'd15, 4'd0, 8'd1);
        // zero step lets a countdown start from zero seconds
        run_phase(12'd0, 4'd7, 4'd3, 8'd2);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(12'd37, 4'd9, 4'd9, 8'd6);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && timer_results_due.size() == 0) begin
            $display("countdown_timer_mode_controller_core_tb passed");
        end else begin
            $display("countdown_timer_mode_controller_core_tb failed");
        end
        $finish;
    end

endmodule
